// ----- sv/work_stealing_deque_scheduler_macros.svh -----
// Assertion macros used by the checker file.
`ifndef WORK_STEALING_DEQUE_SCHEDULER_MACROS_SVH
`define WORK_STEALING_DEQUE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/wsd_pkg.sv -----
// Package: codes, field widths and sequencer states of the deque scheduler.
package wsd_pkg;

	localparam int JOB_W  = 16;
	localparam int WRK_W  = 3;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 4;
	localparam int CMP_W  = 8;

	localparam logic FUNC_ENQ   = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd3;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ENQ,
		ST_OWN,
		ST_SCAN,
		ST_FINISH
	} wsd_state_t;

endpackage

// ----- sv/wsd_ifs.sv -----
// Channel interfaces: request, result and configuration words.
interface wsd_req_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [wsd_pkg::JOB_W-1:0]  job_id;
	logic [wsd_pkg::WRK_W-1:0]  worker;
	modport source (output valid, func, job_id, worker, input ready);
	modport sink   (input valid, func, job_id, worker, output ready);
endinterface

interface wsd_res_if;
	logic                       valid;
	logic                       ready;
	logic                       job_valid;
	logic [wsd_pkg::JOB_W-1:0]  job_out;
	logic [wsd_pkg::WRK_W-1:0]  from_queue;
	logic                       stolen;
	logic [wsd_pkg::STAT_W-1:0] status;
	modport source (output valid, job_valid, job_out, from_queue, stolen, status, input ready);
	modport sink   (input valid, job_valid, job_out, from_queue, stolen, status, output ready);
endinterface

interface wsd_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [wsd_pkg::CFG_W-1:0]  active_workers;
	modport source (output valid, active_workers, input ready);
	modport sink   (input valid, active_workers, output ready);
endinterface

// ----- sv/wsd_store.sv -----
// Job store: one write port, one registered read port.
module wsd_store #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 16,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/work_stealing_deque_scheduler.sv -----
// Top level: per-worker job deques with round-robin enqueue and stealing fetch.
//
//  channel  dir  word                                              handshake
//  req      in   func, job_id, worker                              valid/ready
//  result   out  job_valid, job_out, from_queue, stolen, status    valid/ready
//  cfg      in   active_workers                                    valid/ready (ready = 1)
//
// Enqueue and own-queue pop pass DISPATCH, ENQ or OWN, and FINISH to the result register.
// An out-of-range fetch passes DISPATCH and FINISH and returns status RANGE.
// An empty own queue sends a fetch to SCAN, which checks the other active queues in turn,
// wrapping past the last, and steals the front job of the first that holds one, else EMPTY.
// One request is in flight; req.ready is high only while the sequencer is idle.
// The result register frees the sequencer: a new request is taken while a result waits.
// Reset clears queue fronts, counts and the round-robin pointer; store content is unset.
module work_stealing_deque_scheduler #(
	parameter int WORKERS     = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	wsd_req_if.sink   req,
	wsd_res_if.source result,
	wsd_cfg_if.sink   cfg
);

	localparam int WW   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int NW   = $clog2(WORKERS + 1);
	localparam int FW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW   = ((FW > CNTW) ? FW : CNTW) + 1;
	localparam int MD   = WORKERS * QUEUE_DEPTH;
	localparam int AW   = (MD > 2) ? $clog2(MD) : 1;
	localparam int CW   = wsd_pkg::CMP_W;

	wsd_pkg::wsd_state_t state_q, state_d;

	logic [wsd_pkg::CFG_W-1:0] aw_q;
	logic [WW-1:0]             rr_q;
	logic [FW-1:0]             front_q [WORKERS];
	logic [CNTW-1:0]           count_q [WORKERS];
	logic                      out_valid_q;

	logic                        func_q;
	logic [ID_WIDTH-1:0]         job_q;
	logic [wsd_pkg::WRK_W-1:0]   worker_q;
	logic [WW-1:0]               cur_q;
	logic [NW-1:0]               step_q;
	logic                        res_valid_q;
	logic [WW-1:0]               res_from_q;
	logic                        res_stolen_q;
	logic [wsd_pkg::STAT_W-1:0]  res_status_q;
	logic                        out_jv_q;
	logic [wsd_pkg::JOB_W-1:0]   out_job_q;
	logic [wsd_pkg::WRK_W-1:0]   out_from_q;
	logic                        out_stolen_q;
	logic [wsd_pkg::STAT_W-1:0]  out_status_q;

	logic [CW-1:0]       n_c;
	logic [WW-1:0]       rr_sel, rr_next, next_cur;
	logic                worker_ok;
	logic [CNTW-1:0]     cur_count;
	logic [FW-1:0]       cur_front, front_inc;
	logic                cur_full, cur_empty, scan_done;
	logic [CNTW-1:0]     offset;
	logic [SW-1:0]       slot_sum, slot_wrap;
	logic [FW-1:0]       slot;
	logic [AW-1:0]       addr;
	logic                out_free;
	logic                mem_we, mem_re;
	logic [ID_WIDTH-1:0] mem_rdata;

	// active queue count, clamped to 1..WORKERS
	always_comb begin
		if (aw_q == '0) begin
			n_c = CW'(1);
		end else if (CW'(aw_q) > CW'(WORKERS)) begin
			n_c = CW'(WORKERS);
		end else begin
			n_c = CW'(aw_q);
		end
	end

	assign rr_sel    = (CW'(rr_q) >= n_c) ? '0 : rr_q;
	assign rr_next   = (CW'(rr_sel) + CW'(1) >= n_c) ? '0 : rr_sel + WW'(1);
	assign next_cur  = (CW'(cur_q) + CW'(1) >= n_c) ? '0 : cur_q + WW'(1);
	assign worker_ok = CW'(worker_q) < n_c;
	assign cur_count = count_q[cur_q];
	assign cur_front = front_q[cur_q];
	assign front_inc = (cur_front == FW'(QUEUE_DEPTH - 1)) ? '0 : cur_front + FW'(1);
	assign cur_full  = (cur_count == CNTW'(QUEUE_DEPTH));
	assign cur_empty = (cur_count == '0);
	assign scan_done = (CW'(step_q) >= n_c);
	assign out_free  = !out_valid_q || result.ready;

	always_comb begin
		unique case (state_q)
			wsd_pkg::ST_ENQ: offset = cur_count;
			wsd_pkg::ST_OWN: offset = cur_count - CNTW'(1);
			default:         offset = '0;
		endcase
	end

	assign slot_sum  = SW'(cur_front) + SW'(offset);
	assign slot_wrap = (slot_sum >= SW'(QUEUE_DEPTH)) ? slot_sum - SW'(QUEUE_DEPTH) : slot_sum;
	assign slot      = FW'(slot_wrap);
	assign addr      = AW'(cur_q) * AW'(QUEUE_DEPTH) + AW'(slot);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wsd_pkg::ST_IDLE: begin
				if (req.valid) state_d = wsd_pkg::ST_DISPATCH;
			end
			wsd_pkg::ST_DISPATCH: begin
				if (func_q == wsd_pkg::FUNC_ENQ) state_d = wsd_pkg::ST_ENQ;
				else if (worker_ok)              state_d = wsd_pkg::ST_OWN;
				else                             state_d = wsd_pkg::ST_FINISH;
			end
			wsd_pkg::ST_ENQ: state_d = wsd_pkg::ST_FINISH;
			wsd_pkg::ST_OWN: begin
				state_d = cur_empty ? wsd_pkg::ST_SCAN : wsd_pkg::ST_FINISH;
			end
			wsd_pkg::ST_SCAN: begin
				if (scan_done || !cur_empty) state_d = wsd_pkg::ST_FINISH;
			end
			wsd_pkg::ST_FINISH: begin
				if (out_free) state_d = wsd_pkg::ST_IDLE;
			end
			default: state_d = wsd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			wsd_pkg::ST_IDLE: req.ready = 1'b1;
			wsd_pkg::ST_ENQ:  mem_we = !cur_full;
			wsd_pkg::ST_OWN:  mem_re = !cur_empty;
			wsd_pkg::ST_SCAN: mem_re = !scan_done && !cur_empty;
			default: ;
		endcase
	end

	wsd_store #(
		.DEPTH (MD),
		.WIDTH (ID_WIDTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr),
		.wdata (job_q),
		.re    (mem_re),
		.raddr (addr),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsd_pkg::ST_IDLE;
			aw_q        <= wsd_pkg::ACTIVE_RESET;
			rr_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WORKERS; i++) begin
				front_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				aw_q <= cfg.active_workers;
			end
			if (state_q == wsd_pkg::ST_DISPATCH && func_q == wsd_pkg::FUNC_ENQ) begin
				rr_q <= rr_next;
			end
			if (mem_we) begin
				count_q[cur_q] <= cur_count + CNTW'(1);
			end
			if (mem_re) begin
				count_q[cur_q] <= cur_count - CNTW'(1);
				if (state_q == wsd_pkg::ST_SCAN) begin
					front_q[cur_q] <= front_inc;
				end
			end
			if (state_q == wsd_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result words
	always_ff @(posedge clk) begin
		unique case (state_q)
			wsd_pkg::ST_IDLE: begin
				if (req.valid) begin
					func_q   <= req.func;
					job_q    <= ID_WIDTH'(req.job_id);
					worker_q <= req.worker;
				end
			end
			wsd_pkg::ST_DISPATCH: begin
				res_valid_q  <= 1'b0;
				res_stolen_q <= 1'b0;
				res_status_q <= wsd_pkg::STATUS_OK;
				res_from_q   <= '0;
				if (func_q == wsd_pkg::FUNC_ENQ) begin
					cur_q      <= rr_sel;
					res_from_q <= rr_sel;
				end else if (worker_ok) begin
					cur_q <= WW'(worker_q);
				end else begin
					res_status_q <= wsd_pkg::STATUS_RANGE;
				end
			end
			wsd_pkg::ST_ENQ: begin
				if (cur_full) res_status_q <= wsd_pkg::STATUS_FULL;
			end
			wsd_pkg::ST_OWN: begin
				if (!cur_empty) begin
					res_valid_q <= 1'b1;
					res_from_q  <= cur_q;
				end else begin
					cur_q  <= next_cur;
					step_q <= NW'(1);
				end
			end
			wsd_pkg::ST_SCAN: begin
				if (scan_done) begin
					res_status_q <= wsd_pkg::STATUS_EMPTY;
				end else if (!cur_empty) begin
					res_valid_q  <= 1'b1;
					res_stolen_q <= 1'b1;
					res_from_q   <= cur_q;
				end else begin
					cur_q  <= next_cur;
					step_q <= step_q + NW'(1);
				end
			end
			wsd_pkg::ST_FINISH: begin
				if (out_free) begin
					out_jv_q     <= res_valid_q;
					out_job_q    <= res_valid_q ? wsd_pkg::JOB_W'(mem_rdata) : '0;
					out_from_q   <= wsd_pkg::WRK_W'(res_from_q);
					out_stolen_q <= res_stolen_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid      = out_valid_q;
	assign result.job_valid  = out_jv_q;
	assign result.job_out    = out_job_q;
	assign result.from_queue = out_from_q;
	assign result.stolen     = out_stolen_q;
	assign result.status     = out_status_q;
	assign cfg.ready         = 1'b1;

endmodule

// ----- sv/wsd_checker.sv -----
// Port checker for the deque scheduler and its bind.
`include "work_stealing_deque_scheduler_macros.svh"

module wsd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       job_valid,
	input logic [wsd_pkg::JOB_W-1:0]  job_out,
	input logic                       stolen,
	input logic [wsd_pkg::STAT_W-1:0] status
);

	`WSD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`WSD_ASSERT_NOW(a_job_ok, clk, arst_n, out_valid && job_valid, status == wsd_pkg::STATUS_OK)
	`WSD_ASSERT_NOW(a_fail_clear, clk, arst_n, out_valid && status != wsd_pkg::STATUS_OK, !job_valid && job_out == '0 && !stolen)
	`WSD_ASSERT_NOW(a_steal_job, clk, arst_n, out_valid && stolen, job_valid)

endmodule

bind work_stealing_deque_scheduler wsd_checker u_wsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.job_valid (result.job_valid),
	.job_out   (result.job_out),
	.stolen    (result.stolen),
	.status    (result.status)
);

// ----- verif/tb_work_stealing_deque_scheduler.sv -----
// Testbench: random and directed job traffic checked against a deque scheduler predictor.
`timescale 1ns / 1ps

module tb_work_stealing_deque_scheduler;

	localparam int WORKERS     = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;

	typedef struct packed {
		logic                       job_valid;
		logic [wsd_pkg::JOB_W-1:0]  job_out;
		logic [wsd_pkg::WRK_W-1:0]  from_queue;
		logic                       stolen;
		logic [wsd_pkg::STAT_W-1:0] status;
	} sched_result_t;

	logic clk;
	logic arst_n;

	wsd_req_if req_ch ();
	wsd_res_if res_ch ();
	wsd_cfg_if cfg_ch ();

	work_stealing_deque_scheduler #(
		.WORKERS     (WORKERS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	logic [wsd_pkg::JOB_W-1:0] job_slots [WORKERS][QUEUE_DEPTH];
	int                        slot_front [WORKERS];
	int                        slot_count [WORKERS];
	int                        rr_next;
	logic [wsd_pkg::CFG_W-1:0] active_setting;

	sched_result_t pending_results [$];

	int  error_count;
	int  words_sent;
	int  cfg_writes;
	int  seen_pop, seen_steal, seen_empty, seen_full, seen_range, seen_enq;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  req_up;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb_work_stealing_deque_scheduler NOT OK");
		$finish;
	end

	function automatic int effective_count(logic [wsd_pkg::CFG_W-1:0] setting);
		if (setting == 0)
			return 1;
		if (setting > WORKERS)
			return WORKERS;
		return setting;
	endfunction

	function automatic sched_result_t schedule_request(logic f,
			logic [wsd_pkg::JOB_W-1:0] job, logic [wsd_pkg::WRK_W-1:0] w);
		sched_result_t r;
		int n;
		int q;
		int v;
		int i;
		bit found;
		r = '0;
		n = effective_count(active_setting);
		if (f == wsd_pkg::FUNC_ENQ) begin
			q = (rr_next >= n) ? 0 : rr_next;
			rr_next = (q + 1 >= n) ? 0 : q + 1;
			r.from_queue = wsd_pkg::WRK_W'(q);
			if (slot_count[q] >= QUEUE_DEPTH) begin
				r.status = wsd_pkg::STATUS_FULL;
			end else begin
				job_slots[q][(slot_front[q] + slot_count[q]) % QUEUE_DEPTH] = job;
				slot_count[q]++;
			end
		end else if (w >= n) begin
			r.status = wsd_pkg::STATUS_RANGE;
		end else if (slot_count[w] != 0) begin
			r.job_out = job_slots[w][(slot_front[w] + slot_count[w] - 1) % QUEUE_DEPTH];
			slot_count[w]--;
			r.job_valid = 1'b1;
			r.from_queue = w;
		end else begin
			r.status = wsd_pkg::STATUS_EMPTY;
			found = 1'b0;
			for (i = 1; i < n; i++) begin
				v = (w + i) % n;
				if (!found && slot_count[v] != 0) begin
					r.job_out = job_slots[v][slot_front[v]];
					slot_front[v] = (slot_front[v] + 1) % QUEUE_DEPTH;
					slot_count[v]--;
					r.job_valid = 1'b1;
					r.from_queue = wsd_pkg::WRK_W'(v);
					r.stolen = 1'b1;
					r.status = wsd_pkg::STATUS_OK;
					found = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, int want, int got);
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		sched_result_t want;
		sched_result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.job_valid, res_ch.job_out, res_ch.from_queue, res_ch.stolen,
				res_ch.status};
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result word, expected none, actual %0h",
					$time, got);
				error_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (got.job_valid !== want.job_valid)
					report_mismatch("job_valid", want.job_valid, got.job_valid);
				if (got.job_out !== want.job_out)
					report_mismatch("job_out", want.job_out, got.job_out);
				if (got.from_queue !== want.from_queue)
					report_mismatch("from_queue", want.from_queue, got.from_queue);
				if (got.stolen !== want.stolen)
					report_mismatch("stolen", want.stolen, got.stolen);
				if (got.status !== want.status)
					report_mismatch("status", want.status, got.status);
				unique case (want.status)
					wsd_pkg::STATUS_EMPTY: seen_empty++;
					wsd_pkg::STATUS_FULL:  seen_full++;
					wsd_pkg::STATUS_RANGE: seen_range++;
					default: begin
						if (want.stolen)
							seen_steal++;
						else if (want.job_valid)
							seen_pop++;
						else
							seen_enq++;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic lower_req();
		if (req_up) begin
			req_ch.valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	task automatic send_request(logic f, logic [wsd_pkg::JOB_W-1:0] job,
			logic [wsd_pkg::WRK_W-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			lower_req();
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.func   <= f;
		req_ch.job_id <= job;
		req_ch.worker <= w;
		req_up = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.insert(pending_results.size(), schedule_request(f, job, w));
		words_sent++;
	endtask

	task automatic wait_drained();
		lower_req();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_active(logic [wsd_pkg::CFG_W-1:0] setting);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.active_workers <= setting;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		active_setting = setting;
		cfg_writes++;
	endtask

	task automatic test_empty_after_reset();
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd0);
		send_request(wsd_pkg::FUNC_FETCH, 16'hFFFF, 3'd7);
	endtask

	task automatic test_pop_and_steal();
		send_request(wsd_pkg::FUNC_ENQ, 16'h0000, 3'd7);
		send_request(wsd_pkg::FUNC_ENQ, 16'hFFFF, 3'd0);
		send_request(wsd_pkg::FUNC_ENQ, 16'h1234, 3'd5);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd0);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd0);
		send_request(wsd_pkg::FUNC_FETCH, 16'hFFFF, 3'd5);
	endtask

	// shrink with the pointer at the count, zero and oversize counts, parked queues
	task automatic test_active_count_limits();
		write_active(4'd3);
		send_request(wsd_pkg::FUNC_ENQ, 16'hA5A5, 3'd0);
		send_request(wsd_pkg::FUNC_ENQ, 16'h5A5A, 3'd0);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd3);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd7);
		write_active(4'd0);
		send_request(wsd_pkg::FUNC_ENQ, 16'hC3C3, 3'd4);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd1);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd0);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd0);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd0);
		write_active(4'd15);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd7);
		send_request(wsd_pkg::FUNC_FETCH, 16'h0000, 3'd6);
	endtask

	task automatic test_random_traffic();
		logic [wsd_pkg::CFG_W-1:0] settings [0:11];
		int                        enq_bias [0:11];
		int                        p;
		int                        k;
		int                        n;
		logic                      f;
		logic [wsd_pkg::JOB_W-1:0] job;
		logic [wsd_pkg::WRK_W-1:0] w;
		settings = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd9, 4'd8, 4'd4, 4'd6, 4'd7};
		enq_bias = '{55, 85, 30, 70, 85, 45, 80, 25, 90, 50, 35, 60};
		for (p = 0; p < 12; p++) begin
			if (p == 4) begin
				send_idle_pct = 62;
				recv_idle_pct = 29;
			end else if (p == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_active(settings[p]);
			n = effective_count(settings[p]);
			for (k = 0; k < 150; k++) begin
				f = ($urandom_range(99) < enq_bias[p]) ? wsd_pkg::FUNC_ENQ : wsd_pkg::FUNC_FETCH;
				case ($urandom_range(19))
					0: job = '0;
					1: job = '1;
					default: job = wsd_pkg::JOB_W'($urandom);
				endcase
				w = wsd_pkg::WRK_W'(($urandom_range(4) == 0) ? $urandom_range(7)
					: $urandom_range(n - 1));
				send_request(f, job, w);
				if ($urandom_range(99) < 2)
					wait_drained();
			end
		end
	endtask

	initial begin
		int q;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.func       = wsd_pkg::FUNC_ENQ;
		req_ch.job_id     = '0;
		req_ch.worker     = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.active_workers = wsd_pkg::ACTIVE_RESET;
		req_up            = 1'b0;
		error_count       = 0;
		words_sent        = 0;
		cfg_writes        = 0;
		seen_pop = 0; seen_steal = 0; seen_empty = 0;
		seen_full = 0; seen_range = 0; seen_enq = 0;
		for (q = 0; q < WORKERS; q++) begin
			slot_front[q] = 0;
			slot_count[q] = 0;
		end
		rr_next        = 0;
		active_setting = wsd_pkg::ACTIVE_RESET;
		send_idle_pct  = 29;
		recv_idle_pct  = 62;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_after_reset();
		test_pop_and_steal();
		test_active_count_limits();
		test_random_traffic();

		wait_drained();
		repeat (20) @(posedge clk);
		error_count += pending_results.size();
		$display("run: %0d request words, %0d active-count writes, %0d enqueues accepted",
			words_sent, cfg_writes, seen_enq);
		$display("run: %0d own pops, %0d steals, %0d empty, %0d full drops, %0d out of range",
			seen_pop, seen_steal, seen_empty, seen_full, seen_range);
		if (error_count == 0)
			$display("tb_work_stealing_deque_scheduler OK");
		else
			$display("tb_work_stealing_deque_scheduler NOT OK");
		$finish;
	end

endmodule
